FILE: rtl/core/mqttpp_pkg.sv
// Package for the MQTT PUBLISH packet parser core.
// Holds the parser phase type, the result kind and error codes, and the header constants.
// No dependencies.
package mqttpp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_PKTID   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TOPIC   = 2'd0,
    KIND_PKTID   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_HEADER    = 2'd1,
    ERR_LEN_LONG  = 2'd2,
    ERR_LEN_SHORT = 2'd3
  } err_t;

  localparam logic [7:0] HDR_QOS0 = 8'h30;
  localparam logic [7:0] HDR_QOS1 = 8'h32;
  localparam logic [7:0] HDR_QOS2 = 8'h34;

  localparam int unsigned LEN_W       = 28;
  localparam int unsigned TOPIC_LEN_W = 16;
  localparam int unsigned GROUP_W     = 7;
  localparam logic [1:0]  LEN_IDX_MAX = 2'd3;
  localparam logic [15:0] PKTID_BYTES = 16'd2;

endpackage

FILE: rtl/core/mqtt_publish_packet_parser_core.sv
// MQTT PUBLISH packet parser core: one received byte per transfer.
// Latency: a result is valid in the cycle after the input transfer that causes it.
// Throughput: one byte per cycle (one state update each) unless a result is held.
// The output register is refilled in the same cycle it is drained.
// Reset (synchronous, active low) returns the parser to idle and empties the output.
// Depends on mqttpp_pkg.
module mqtt_publish_packet_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_error_code,
  output logic        out_qos_nonzero,
  output logic [15:0] out_topic_length,
  output logic [27:0] out_payload_length,
  output logic        out_last
);
  import mqttpp_pkg::*;

  phase_t                   phase_r, phase_nxt;
  logic [LEN_W-1:0]         rem_len_r, rem_len_nxt;
  logic [1:0]               len_idx_r, len_idx_nxt;
  logic [TOPIC_LEN_W-1:0]   topic_len_r, topic_len_nxt;
  logic [TOPIC_LEN_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0]         payload_left_r, payload_left_nxt;
  logic [LEN_W-1:0]         payload_total_r, payload_total_nxt;
  logic                     qos_r, qos_nxt;

  logic                     out_valid_r;
  logic [7:0]               out_byte_r;
  kind_t                    out_kind_r;
  err_t                     out_err_r;
  logic                     out_qos_r;
  logic [TOPIC_LEN_W-1:0]   out_topic_r;
  logic [LEN_W-1:0]         out_plen_r;
  logic                     out_last_r;

  logic                     res_valid;
  logic [7:0]               res_byte;
  kind_t                    res_kind;
  err_t                     res_err;
  logic [LEN_W-1:0]         res_plen;
  logic                     res_last;

  logic                     in_xfer;
  logic [4:0]               shamt;
  logic [TOPIC_LEN_W-1:0]   topic_full;
  logic [TOPIC_LEN_W:0]     overhead;
  logic [LEN_W-1:0]         plen_calc;
  logic [TOPIC_LEN_W-1:0]   bytes_dec;
  logic [LEN_W-1:0]         payload_dec;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign shamt      = 5'(len_idx_r) * 5'(GROUP_W);
  assign topic_full = {topic_len_r[15:8], in_data_byte};
  assign overhead   = 17'(topic_full) + 17'd2 + (qos_r ? 17'd2 : 17'd0);
  assign plen_calc  = rem_len_r - LEN_W'(overhead);
  assign bytes_dec  = bytes_left_r - 16'd1;
  assign payload_dec = payload_left_r - 28'd1;

  always_comb begin
    phase_nxt         = phase_r;
    rem_len_nxt       = rem_len_r;
    len_idx_nxt       = len_idx_r;
    topic_len_nxt     = topic_len_r;
    bytes_left_nxt    = bytes_left_r;
    payload_left_nxt  = payload_left_r;
    payload_total_nxt = payload_total_r;
    qos_nxt           = qos_r;
    res_valid = 1'b0;
    res_byte  = in_data_byte;
    res_kind  = KIND_TOPIC;
    res_err   = ERR_NONE;
    res_plen  = payload_total_r;
    res_last  = 1'b0;

    if (in_packet_start) begin
      rem_len_nxt       = '0;
      len_idx_nxt       = '0;
      topic_len_nxt     = '0;
      bytes_left_nxt    = '0;
      payload_left_nxt  = '0;
      payload_total_nxt = '0;
      qos_nxt           = 1'b0;
      if (in_data_byte != HDR_QOS0 && in_data_byte != HDR_QOS1 &&
          in_data_byte != HDR_QOS2) begin
        phase_nxt = PH_IDLE;
        res_valid = 1'b1;
        res_err   = ERR_HEADER;
      end else begin
        qos_nxt   = (in_data_byte != HDR_QOS0);
        phase_nxt = PH_LEN;
      end
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          // Seven bits per length byte, least significant group first.
          rem_len_nxt = rem_len_r + (LEN_W'(in_data_byte[6:0]) << shamt);
          if (in_data_byte[7]) begin
            if (len_idx_r == LEN_IDX_MAX) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res_err   = ERR_LEN_LONG;
            end else begin
              len_idx_nxt = len_idx_r + 2'd1;
            end
          end else begin
            phase_nxt = PH_TLEN_HI;
          end
        end
        PH_TLEN_HI: begin
          topic_len_nxt = {in_data_byte, 8'd0};
          phase_nxt     = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          topic_len_nxt = topic_full;
          if (rem_len_r < LEN_W'(overhead)) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_err   = ERR_LEN_SHORT;
          end else begin
            payload_left_nxt  = plen_calc;
            payload_total_nxt = plen_calc;
            if (topic_full != '0) begin
              phase_nxt      = PH_TOPIC;
              bytes_left_nxt = topic_full;
            end else if (qos_r) begin
              phase_nxt      = PH_PKTID;
              bytes_left_nxt = PKTID_BYTES;
            end else if (plen_calc != '0) begin
              phase_nxt = PH_PAYLOAD;
            end else begin
              // Empty packet: nothing to deliver.
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_TOPIC: begin
          res_valid      = 1'b1;
          res_kind       = KIND_TOPIC;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == '0) begin
            if (qos_r) begin
              phase_nxt      = PH_PKTID;
              bytes_left_nxt = PKTID_BYTES;
            end else if (payload_left_r != '0) begin
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
              res_last  = 1'b1;
            end
          end
        end
        PH_PKTID: begin
          res_valid      = 1'b1;
          res_kind       = KIND_PKTID;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == '0) begin
            if (payload_left_r != '0) begin
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
              res_last  = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res_kind         = KIND_PAYLOAD;
          payload_left_nxt = payload_dec;
          if (payload_dec == '0) begin
            phase_nxt = PH_IDLE;
            res_last  = 1'b1;
          end
        end
        default: begin
          // Idle: stray bytes without a start flag are dropped.
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (res_err != ERR_NONE) begin
      res_kind = KIND_ERROR;
      res_byte = 8'd0;
      res_plen = '0;
      res_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      rem_len_r       <= '0;
      len_idx_r       <= '0;
      topic_len_r     <= '0;
      bytes_left_r    <= '0;
      payload_left_r  <= '0;
      payload_total_r <= '0;
      qos_r           <= 1'b0;
    end else if (in_xfer) begin
      phase_r         <= phase_nxt;
      rem_len_r       <= rem_len_nxt;
      len_idx_r       <= len_idx_nxt;
      topic_len_r     <= topic_len_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_left_r  <= payload_left_nxt;
      payload_total_r <= payload_total_nxt;
      qos_r           <= qos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_xfer && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_byte_r  <= res_byte;
      out_kind_r  <= res_kind;
      out_err_r   <= res_err;
      out_qos_r   <= qos_nxt;
      out_topic_r <= topic_len_nxt;
      out_plen_r  <= res_plen;
      out_last_r  <= res_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_kind           = out_kind_r;
  assign out_error_code     = out_err_r;
  assign out_qos_nonzero    = out_qos_r;
  assign out_topic_length   = out_topic_r;
  assign out_payload_length = out_plen_r;
  assign out_last           = out_last_r;

  // An error report always ends the packet with an empty byte and no payload length.
  a_err_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_ERROR |->
      out_last_r && out_byte_r == 8'd0 && out_plen_r == '0)
    else $error("error report without last or with nonzero fields");

  // The error code is set exactly on error reports.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_ERROR) == (out_err_r != ERR_NONE)))
    else $error("error code and result kind disagree");

  // A held result must block the input side.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while result is stalled");

  // The payload phase is only ever occupied with bytes still to come.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> payload_left_r != '0)
    else $error("payload phase with no payload bytes left");

endmodule

FILE: sim/mqtt_publish_packet_parser_core_tb.sv
// Self-checking testbench for the MQTT PUBLISH packet parser core.
// Drives byte streams with random idling and checks each delivery against a built-in parser model.
// Depends on mqttpp_pkg and mqtt_publish_packet_parser_core.
`timescale 1ns / 1ps

module mqtt_publish_packet_parser_core_tb;
  import mqttpp_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    err_t        err;
    logic        qos;
    logic [15:0] tlen;
    logic [27:0] plen;
    logic        last;
  } delivery_t;

  class parser_scoreboard;
    phase_t      phase;
    logic [27:0] rem_len;
    logic [1:0]  len_idx;
    logic [15:0] tlen;
    logic [27:0] left;
    logic [27:0] payload_left;
    logic        qos;
    delivery_t   expected_deliveries[$];
    int unsigned n_bytes;
    int unsigned n_checked;
    int unsigned n_error_reports;
    int unsigned n_finished;
    int unsigned n_mismatch;

    function new();
      clear_packet();
      phase = PH_IDLE;
      n_bytes = 0;
      n_checked = 0;
      n_error_reports = 0;
      n_finished = 0;
      n_mismatch = 0;
    endfunction

    function void clear_packet();
      rem_len = '0;
      len_idx = '0;
      tlen = '0;
      left = '0;
      payload_left = '0;
      qos = 1'b0;
    endfunction

    function int unsigned overhead();
      return 32'd2 + 32'(tlen) + (qos ? 32'd2 : 32'd0);
    endfunction

    function logic [27:0] payload_total();
      if (32'(rem_len) < overhead()) return '0;
      return 28'(32'(rem_len) - overhead());
    endfunction

    function delivery_t make_delivery(logic [7:0] b, kind_t k, err_t e, logic [27:0] p, bit l);
      delivery_t d;
      d.data = b;
      d.kind = k;
      d.err = e;
      d.qos = qos;
      d.tlen = tlen;
      d.plen = p;
      d.last = l;
      return d;
    endfunction

    function delivery_t error_report(err_t e);
      phase = PH_IDLE;
      return make_delivery(8'h00, KIND_ERROR, e, '0, 1'b1);
    endfunction

    // Returns 1 when the packet ends right after the topic field.
    function bit after_topic();
      if (qos) begin
        phase = PH_PKTID;
        left = 28'(PKTID_BYTES);
        return 1'b0;
      end
      if (payload_left != 0) begin
        phase = PH_PAYLOAD;
        return 1'b0;
      end
      phase = PH_IDLE;
      return 1'b1;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte produces a delivery.
    function bit parse_byte(input logic [7:0] b, input bit s, output delivery_t d);
      bit done;
      d = '0;
      done = 1'b0;
      if (s) begin
        clear_packet();
        if (b != HDR_QOS0 && b != HDR_QOS1 && b != HDR_QOS2) begin
          d = error_report(ERR_HEADER);
          return 1'b1;
        end
        qos = (b != HDR_QOS0);
        phase = PH_LEN;
        return 1'b0;
      end
      case (phase)
        PH_LEN: begin
          rem_len = rem_len + (28'(b[6:0]) << (GROUP_W * len_idx));
          if (b[7]) begin
            if (len_idx >= LEN_IDX_MAX) begin
              d = error_report(ERR_LEN_LONG);
              return 1'b1;
            end
            len_idx = len_idx + 2'd1;
          end else begin
            phase = PH_TLEN_HI;
          end
          return 1'b0;
        end
        PH_TLEN_HI: begin
          tlen = {b, 8'h00};
          phase = PH_TLEN_LO;
          return 1'b0;
        end
        PH_TLEN_LO: begin
          tlen[7:0] = b;
          if (32'(rem_len) < overhead()) begin
            d = error_report(ERR_LEN_SHORT);
            return 1'b1;
          end
          payload_left = payload_total();
          if (tlen != 0) begin
            phase = PH_TOPIC;
            left = 28'(tlen);
          end else begin
            void'(after_topic());
          end
          return 1'b0;
        end
        PH_TOPIC: begin
          left = left - 28'd1;
          if (left == 0) done = after_topic();
          d = make_delivery(b, KIND_TOPIC, ERR_NONE, payload_total(), done);
          return 1'b1;
        end
        PH_PKTID: begin
          left = left - 28'd1;
          if (left == 0) begin
            if (payload_left != 0) begin
              phase = PH_PAYLOAD;
            end else begin
              phase = PH_IDLE;
              done = 1'b1;
            end
          end
          d = make_delivery(b, KIND_PKTID, ERR_NONE, payload_total(), done);
          return 1'b1;
        end
        PH_PAYLOAD: begin
          payload_left = payload_left - 28'd1;
          done = (payload_left == 0);
          if (done) phase = PH_IDLE;
          d = make_delivery(b, KIND_PAYLOAD, ERR_NONE, payload_total(), done);
          return 1'b1;
        end
        default: begin
          phase = PH_IDLE;
          return 1'b0;
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b, bit s);
      delivery_t d;
      n_bytes++;
      if (parse_byte(b, s, d)) expected_deliveries.push_back(d);
    endfunction

    task log_mismatch(input string what);
      n_mismatch++;
      $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    task check_delivery(input delivery_t got);
      delivery_t want;
      if (expected_deliveries.size() == 0) begin
        log_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_deliveries.pop_front();
      n_checked++;
      if (want.kind == KIND_ERROR) n_error_reports++;
      else if (want.last) n_finished++;
      if (got !== want)
        log_mismatch($sformatf(
          "byte %h/%h kind %0d/%0d err %0d/%0d qos %0d/%0d tlen %h/%h plen %h/%h last %0d/%0d",
          got.data, want.data, got.kind, want.kind, got.err, want.err, got.qos, want.qos,
          got.tlen, want.tlen, got.plen, want.plen, got.last, want.last));
    endtask

    function int unsigned pending();
      return expected_deliveries.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_packet_start;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic [1:0]  out_error_code;
  logic        out_qos_nonzero;
  logic [15:0] out_topic_length;
  logic [27:0] out_payload_length;
  logic        out_last;

  parser_scoreboard board = new();
  delivery_t        seen;
  int unsigned      src_idle_pct = 36;
  int unsigned      sink_idle_pct = 68;
  int unsigned      random_items = 0;
  int unsigned      stall_cycles = 0;

  mqtt_publish_packet_parser_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_packet_start    (in_packet_start),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_kind           (out_kind),
    .out_error_code     (out_error_code),
    .out_qos_nonzero    (out_qos_nonzero),
    .out_topic_length   (out_topic_length),
    .out_payload_length (out_payload_length),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Transfers are sampled at the edge, before any register in the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_byte(in_data_byte, in_packet_start);
      if (out_valid && out_ready) begin
        seen.data = out_byte;
        seen.kind = kind_t'(out_kind);
        seen.err  = err_t'(out_error_code);
        seen.qos  = out_qos_nonzero;
        seen.tlen = out_topic_length;
        seen.plen = out_payload_length;
        seen.last = out_last;
        board.check_delivery(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("mqtt_publish_packet_parser_core_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit s, input bit counts);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_packet_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counts) random_items++;
  endtask

  task automatic send_frame(input logic [7:0] frame[$]);
    foreach (frame[i]) send_byte(frame[i], i == 0, 1'b1);
  endtask

  // Header, remaining length (optionally padded with zero groups), topic length, then body.
  task automatic send_packet(input logic [7:0] hdr, input logic [27:0] rem_len,
                             input logic [15:0] tlen, input int unsigned body, input int pad);
    int n;
    send_byte(hdr, 1'b1, 1'b1);
    n = 1;
    while (n < 4 && (rem_len >> (7 * n)) != 0) n++;
    if (n + pad > 4) pad = 4 - n;
    for (int i = 0; i < n + pad; i++)
      send_byte({i < n + pad - 1, rem_len[7 * i +: 7]}, 1'b0, 1'b1);
    send_byte(tlen[15:8], 1'b0, 1'b1);
    send_byte(tlen[7:0], 1'b0, 1'b1);
    repeat (body) send_byte(8'($urandom()), 1'b0, 1'b1);
  endtask

  task automatic random_packet();
    logic [7:0]  hdr;
    logic [15:0] tlen;
    logic [27:0] plen;
    logic [27:0] rem_len;
    int unsigned oh;
    int unsigned body;
    int unsigned pick;
    int          pad;
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0:       hdr = HDR_QOS0;
      1:       hdr = HDR_QOS1;
      default: hdr = HDR_QOS2;
    endcase
    pad = ($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : 0;
    if (pick < 70) begin
      // Well-formed packet; some are cut short and abandoned by the next header.
      tlen = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(0, 6));
      plen = ($urandom_range(9) == 0) ? 28'($urandom_range(13, 60)) : 28'($urandom_range(0, 12));
      oh = 2 + tlen + ((hdr != HDR_QOS0) ? 2 : 0);
      rem_len = 28'(oh) + plen;
      body = rem_len - 2;
      if (pick >= 60 && body > 0) body = $urandom_range(0, body - 1);
      send_packet(hdr, rem_len, tlen, body, pad);
    end else if (pick < 76) begin
      // Huge lengths, truncated after a few bytes.
      rem_len = 28'($urandom());
      tlen = 16'($urandom());
      send_packet(hdr, rem_len, tlen, $urandom_range(0, 4), 0);
    end else if (pick < 82) begin
      tlen = $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(0, 8));
      oh = 2 + tlen + ((hdr != HDR_QOS0) ? 2 : 0);
      rem_len = 28'($urandom_range(0, oh - 1));
      send_packet(hdr, rem_len, tlen, 0, pad);
    end else if (pick < 88) begin
      send_byte(hdr, 1'b1, 1'b1);
      repeat (4) send_byte({1'b1, 7'($urandom())}, 1'b0, 1'b1);
    end else if (pick < 94) begin
      send_byte(8'($urandom()), 1'b1, 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0, 1'b0);
    end
  endtask

  // Holds the sender off until every outstanding delivery has been seen.
  // The first edge lets the monitor note the last accepted byte.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_packet_start <= 1'b0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hFF, 1'b0, 1'b1);                                   // stray byte while idle
    send_frame('{8'h31});                                           // header byte the parser does not accept
    send_frame('{HDR_QOS0, 8'h02, 8'h00, 8'h00});                   // empty packet
    send_frame('{HDR_QOS2, 8'h06, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'h55});
    send_frame('{HDR_QOS0, 8'hFF, 8'hFF, 8'hFF, 8'h80});            // fifth length byte due
    send_frame('{HDR_QOS1, 8'h03, 8'hFF, 8'hFF});                   // length too short
    wait_drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 36 : (ph == 1) ? 68 : 0;
      sink_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 36 : 0;
      while (random_items < RANDOM_ITEMS * (ph + 1) / 3) random_packet();
      wait_drain();
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d accepted bytes and %0d checked deliveries:", board.n_bytes,
             board.n_checked);
    $display("  %0d error reports, %0d packets completed, %0d mismatches.",
             board.n_error_reports, board.n_finished, board.n_mismatch);
    if (board.n_mismatch == 0) begin
      $display("mqtt_publish_packet_parser_core_tb: done, clean");
    end else begin
      $display("mqtt_publish_packet_parser_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: mqtt_publish_packet_parser_core.f
rtl/core/mqttpp_pkg.sv
rtl/core/mqtt_publish_packet_parser_core.sv
sim/mqtt_publish_packet_parser_core_tb.sv
